@@ hw/rtl/irfe_pkg.sv @@
// shared types, widths and codes of the image rotate and flip engine
package irfe_pkg;

    localparam int MAX_DIM    = 128;
    localparam int PIXEL_BITS = 8;

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
    localparam int IDX_W      = ADDR_W + 1;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);
    localparam int FIELD_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_OP   = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] OP_ROT_CW  = 2'd0;
    localparam logic [1:0] OP_ROT_CCW = 2'd1;
    localparam logic [1:0] OP_MIR_LR  = 2'd2;
    localparam logic [1:0] OP_MIR_TB  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    localparam int ORI_SWAP = 0;
    localparam int ORI_FROW = 1;
    localparam int ORI_FCOL = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] pixel_in;
        logic [1:0]         op;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] pixel_out;
        logic               row_end;
        logic               last;
        logic [FIELD_W-1:0] out_rows;
        logic [FIELD_W-1:0] out_cols;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ADDR,
        ST_MEM,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic load;
        logic op_apply;
        logic prep;
        logic div_step;
        logic addr_calc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_oor;
        logic coord_ok;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/image_rotate_flip_engine.sv @@
// top level of the image rotate and flip engine
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in  (kind, pixel_in, op)
// out       output     o_out_valid / i_out_ready o_out (pixel_out, row_end, last, dims)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// load and operation transactions complete in the accept step; a readout steps
// through accept, index check, address multiply, store read and output register
// the first readout after reset, a dimension write or an operation adds a step
// for the serial divide of the read index by the output column count, unless
// the read index has run past the image and restarts at zero
// reset is synchronous; the image store is not cleared
// a stalled output holds the block in its output step, no new transaction is taken
module image_rotate_flip_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  irfe_pkg::t_in_item               i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output irfe_pkg::t_out_item              o_out,
    input  logic                             i_cfg_we,
    input  logic [irfe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [irfe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import irfe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    irfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    irfe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ hw/rtl/irfe_ctrl.sv @@
// controller state machine of the image rotate and flip engine
module irfe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_kind,
    output logic             o_in_ready,
    input  irfe_pkg::t_dp_sts i_sts,
    output irfe_pkg::t_dp_cmd o_cmd
);
    import irfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_kind)
                        KIND_LOAD: o_cmd.load     = 1'b1;
                        KIND_OP:   o_cmd.op_apply = 1'b1;
                        KIND_READ: n_state        = ST_PREP;
                        default:   n_state        = ST_IDLE;
                    endcase
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                // coordinates lost after a dimension or orientation change
                if (!i_sts.idx_oor && !i_sts.coord_ok) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_ADDR;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                n_state         = ST_MEM;
            end
            ST_MEM: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/irfe_dp.sv @@
// datapath of the image rotate and flip engine: store, counters, divider, output register
module irfe_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  irfe_pkg::t_dp_cmd                   i_cmd,
    output irfe_pkg::t_dp_sts                   o_sts,
    input  irfe_pkg::t_in_item                  i_in,
    input  logic                                i_cfg_we,
    input  logic [irfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irfe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output irfe_pkg::t_out_item                 o_out
);
    import irfe_pkg::*;

    logic [PIXEL_BITS-1:0] r_mem [MAX_DIM*MAX_DIM];
    logic [PIXEL_BITS-1:0] r_rd_data;

    logic [CFG_DATA_W-1:0] r_rows_cfg;
    logic [CFG_DATA_W-1:0] r_cols_cfg;
    logic [2:0]            r_orient;
    logic [2:0]            n_orient;
    logic [IDX_W-1:0]      r_load_idx;
    logic [IDX_W-1:0]      r_read_idx;
    logic [DIM_W-1:0]      r_i;
    logic [DIM_W-1:0]      r_j;
    logic                  r_coord_ok;
    logic [ADDR_W-1:0]     r_dvd;
    logic [ADDR_W-1:0]     r_quo;
    logic [DIM_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_row_end;
    logic                  r_last;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [CNT_W-1:0]      dim_r;
    logic [CNT_W-1:0]      dim_c;
    logic [CNT_W-1:0]      out_r;
    logic [CNT_W-1:0]      out_c;
    logic [2*CNT_W-1:0]    prod_total;
    logic [IDX_W-1:0]      total;
    logic                  sw;
    logic                  load_ok;
    logic [CNT_W-1:0]      trial;
    logic                  trial_ge;
    logic [DIM_W-1:0]      rem_next;
    logic [ADDR_W-1:0]     quo_next;
    logic [DIM_W-1:0]      u;
    logic [DIM_W-1:0]      v;
    logic [CNT_W-1:0]      sr_full;
    logic [CNT_W-1:0]      sc_full;
    logic [DIM_W+CNT_W-1:0] addr_full;
    logic                  j_last;
    logic                  idx_last;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
        logic [CNT_W-1:0] res;
        if (d == '0) begin
            res = CNT_W'(1);
        end else if (CNT_W'(d) > CNT_W'(MAX_DIM)) begin
            res = CNT_W'(MAX_DIM);
        end else begin
            res = CNT_W'(d);
        end
        return res;
    endfunction

    assign dim_r      = clamp_dim(r_rows_cfg);
    assign dim_c      = clamp_dim(r_cols_cfg);
    assign sw         = r_orient[ORI_SWAP];
    assign out_r      = sw ? dim_c : dim_r;
    assign out_c      = sw ? dim_r : dim_c;
    assign prod_total = dim_r * dim_c;
    assign total      = prod_total[IDX_W-1:0];
    assign load_ok    = (r_load_idx < total);

    // compose one operation into the orientation
    always_comb begin
        n_orient = r_orient;
        case (i_in.op)
            OP_ROT_CW: begin
                n_orient[sw ? ORI_FCOL : ORI_FROW] = ~r_orient[sw ? ORI_FCOL : ORI_FROW];
                n_orient[ORI_SWAP] = ~sw;
            end
            OP_ROT_CCW: begin
                n_orient[sw ? ORI_FROW : ORI_FCOL] = ~r_orient[sw ? ORI_FROW : ORI_FCOL];
                n_orient[ORI_SWAP] = ~sw;
            end
            OP_MIR_LR: begin
                n_orient[sw ? ORI_FROW : ORI_FCOL] = ~r_orient[sw ? ORI_FROW : ORI_FCOL];
            end
            OP_MIR_TB: begin
                n_orient[sw ? ORI_FCOL : ORI_FROW] = ~r_orient[sw ? ORI_FCOL : ORI_FROW];
            end
            default: begin
                n_orient = r_orient;
            end
        endcase
    end

    // restoring divide of read index by output columns, one bit a step
    assign trial    = {r_rem, r_dvd[ADDR_W-1]};
    assign trial_ge = (trial >= out_c);
    assign rem_next = trial_ge ? DIM_W'(trial - out_c) : trial[DIM_W-1:0];
    assign quo_next = {r_quo[ADDR_W-2:0], trial_ge};

    // output position to source address
    assign u         = sw ? r_j : r_i;
    assign v         = sw ? r_i : r_j;
    assign sr_full   = r_orient[ORI_FROW] ? (dim_r - CNT_W'(1) - CNT_W'(u)) : CNT_W'(u);
    assign sc_full   = r_orient[ORI_FCOL] ? (dim_c - CNT_W'(1) - CNT_W'(v)) : CNT_W'(v);
    assign addr_full = sr_full[DIM_W-1:0] * dim_c + (DIM_W+CNT_W)'(sc_full);
    assign j_last    = ((CNT_W'(r_j) + CNT_W'(1)) == out_c);
    assign idx_last  = ((r_read_idx + IDX_W'(1)) == total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg  <= CFG_DATA_W'(1);
            r_cols_cfg  <= CFG_DATA_W'(1);
            r_orient    <= '0;
            r_load_idx  <= '0;
            r_read_idx  <= '0;
            r_coord_ok  <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default:  r_rows_cfg <= r_rows_cfg;
                endcase
            end
            if (i_cmd.load && load_ok) begin
                r_load_idx <= r_load_idx + IDX_W'(1);
            end
            if (i_cmd.op_apply) begin
                r_orient <= n_orient;
            end
            // coordinates go stale on a dimension write or an operation
            if (i_cfg_we || i_cmd.op_apply) begin
                r_coord_ok <= 1'b0;
            end else if ((i_cmd.prep && o_sts.idx_oor) ||
                         (i_cmd.div_step && o_sts.div_done)) begin
                r_coord_ok <= 1'b1;
            end
            if (i_cmd.prep) begin
                r_div_cnt <= '0;
                if (o_sts.idx_oor) begin
                    r_read_idx <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (i_cmd.addr_calc) begin
                r_read_idx <= idx_last ? '0 : (r_read_idx + IDX_W'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_dvd <= r_read_idx[ADDR_W-1:0];
            r_rem <= '0;
            r_quo <= '0;
            if (o_sts.idx_oor) begin
                r_i <= '0;
                r_j <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[ADDR_W-2:0], 1'b0};
            r_rem <= rem_next;
            r_quo <= quo_next;
            if (o_sts.div_done) begin
                r_i <= quo_next[DIM_W-1:0];
                r_j <= rem_next;
            end
        end
        if (i_cmd.addr_calc) begin
            r_addr    <= addr_full[ADDR_W-1:0];
            r_row_end <= j_last;
            r_last    <= idx_last;
            if (idx_last) begin
                r_i <= '0;
                r_j <= '0;
            end else if (j_last) begin
                r_i <= r_i + DIM_W'(1);
                r_j <= '0;
            end else begin
                r_j <= r_j + DIM_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out.pixel_out <= FIELD_W'(r_rd_data);
            r_out.row_end   <= r_row_end;
            r_out.last      <= r_last;
            r_out.out_rows  <= FIELD_W'(out_r);
            r_out.out_cols  <= FIELD_W'(out_c);
        end
    end

    // image store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_mem[r_load_idx[ADDR_W-1:0]] <= i_in.pixel_in[PIXEL_BITS-1:0];
        end
        r_rd_data <= r_mem[r_addr];
    end

    assign o_sts.idx_oor  = (r_read_idx >= total);
    assign o_sts.coord_ok = r_coord_ok;
    assign o_sts.div_done = (r_div_cnt == DIV_CNT_W'(ADDR_W - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
